>>> hw/rtl/bitmap_and_popcount_density_core_assert.svh
// Assertion macros shared by the density core checkers.
`ifndef BITMAP_AND_POPCOUNT_DENSITY_CORE_ASSERT_SVH
`define BITMAP_AND_POPCOUNT_DENSITY_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BAPD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bapd assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BAPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bapd assertion failed");

// Implication with a delayed consequent, sampled on clk, off during reset.
`define BAPD_ASSERT_TWO(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("bapd assertion failed");

`endif

>>> hw/rtl/bapd_pkg.sv
// Shared types, constants and popcount function for the density core.
package bapd_pkg;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned THR_W     = 22;
	localparam int unsigned POP_W     = $clog2(WORD_BITS + 1);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [THR_W-1:0]     count_t;
	typedef logic [POP_W-1:0]     pop_t;

	// Saturation ceiling of the running count
	localparam count_t COUNT_MAX = '1;

	typedef struct packed {
		word_t  word;
		count_t thr;
		logic   last_coord;
		logic   last_word;
	} item_t;

	typedef struct packed {
		count_t point_count;
		logic   dense_flag;
	} result_t;

	// Count set bits of one bitmap word: pair, nibble and byte sums, then add the bytes
	function automatic pop_t popcount(input word_t w);
		word_t x;
		pop_t  n;
		x = w - ((w >> 1) & {(WORD_BITS/2){2'b01}});
		x = (x & {(WORD_BITS/4){4'b0011}}) + ((x >> 2) & {(WORD_BITS/4){4'b0011}});
		x = (x + (x >> 4)) & {(WORD_BITS/8){8'h0F}};
		n = '0;
		for (int i = 0; i < WORD_BITS / 8; i++) begin
			n = n + pop_t'(x[8*i +: 8]);
		end
		return n;
	endfunction

endpackage

>>> hw/rtl/bapd_in_reg.sv
// Input register stage: captures one transfer per cycle from the input channel while in_stall is low.
module bapd_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  bapd_pkg::item_t  item,
	input  logic             take,
	output logic             valid_s1,
	output bapd_pkg::item_t  item_s1
);

	logic accept;

	// Stall only while the held item cannot move on
	assign in_stall = valid_s1 && !take;
	assign accept   = in_valid && !in_stall;

	// Track occupancy of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Load payload on each transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

endmodule

>>> hw/rtl/bapd_accum.sv
// AND accumulation, popcount, saturating count and density decision.
module bapd_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  bapd_pkg::item_t   item_s1,
	input  logic              out_blocked,
	output logic              take,
	output logic              res_load,
	output bapd_pkg::result_t res
);

	bapd_pkg::word_t  acc_q;
	bapd_pkg::count_t count_q;
	bapd_pkg::count_t thr_max_q;

	bapd_pkg::word_t  acc_and;
	bapd_pkg::count_t thr_new;
	bapd_pkg::pop_t   pop;
	logic [bapd_pkg::THR_W:0] sum;
	bapd_pkg::count_t count_sat;
	logic end_group;
	logic end_unit;

	// Combine the current word with the group and fold it into the count
	always_comb begin
		acc_and   = acc_q & item_s1.word;
		thr_new   = (item_s1.thr > thr_max_q) ? item_s1.thr : thr_max_q;
		pop       = bapd_pkg::popcount(acc_and);
		sum       = {1'b0, count_q} + (bapd_pkg::THR_W + 1)'(pop);
		count_sat = sum[bapd_pkg::THR_W] ? bapd_pkg::COUNT_MAX : sum[bapd_pkg::THR_W-1:0];
		end_group = item_s1.last_coord;
		end_unit  = item_s1.last_coord && item_s1.last_word;
	end

	// Hold the item only when it ends a unit and the result slot is busy
	assign take     = valid_s1 && !(end_unit && out_blocked);
	assign res_load = take && end_unit;

	assign res.point_count = count_sat;
	assign res.dense_flag  = (count_sat >= thr_new);

	// Advance the unit state; rearm everything when the unit closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '1;
			count_q   <= '0;
			thr_max_q <= '0;
		end else if (take) begin
			if (end_unit) begin
				acc_q     <= '1;
				count_q   <= '0;
				thr_max_q <= '0;
			end else begin
				acc_q     <= end_group ? '1 : acc_and;
				count_q   <= end_group ? count_sat : count_q;
				thr_max_q <= thr_new;
			end
		end
	end

endmodule

>>> hw/rtl/bapd_out_reg.sv
// Result register: holds one result until the output transfer completes.
module bapd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_load,
	input  bapd_pkg::result_t res,
	output logic              out_blocked,
	output logic              out_valid,
	input  logic              out_stall,
	output bapd_pkg::count_t  point_count,
	output logic              dense_flag
);

	logic              out_valid_q;
	bapd_pkg::result_t res_q;

	assign out_blocked = out_valid_q && out_stall;

	// Fill on a new result, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture result payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign point_count = res_q.point_count;
	assign dense_flag  = res_q.dense_flag;

endmodule

>>> hw/rtl/bitmap_and_popcount_density_core.sv
// Density core top level: bitmap intersection popcount with dense decision.
// Usage:
//  Input channel (in_valid/in_stall) takes one bitmap word per transfer with
//  its window threshold. Words of one word index arrive back to back, the last
//  marked by last_coord; last_coord together with last_word closes the unit.
//  Output channel (out_valid/out_stall) gives one result per unit: the
//  saturating point count and the dense flag.
//  Throughput: one input transfer per cycle while in_stall is low; the AND,
//  32-bit popcount and saturating add are combinational between the input
//  and result registers. The word that closes a unit passes the input
//  register, then its result the result register, before out_valid shows it.
//  Stall: a waiting result sits in the result register; words that do not
//  close a unit keep flowing. A closing word waits in the input register
//  until the result register frees, and in_stall stays high while it waits.
//  Reset: arst_n clears both channels' valid state, rearms the AND group to
//  all ones and clears the count and largest threshold.
module bitmap_and_popcount_density_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [31:0]            bitmap_word,
	input  logic [21:0]            window_threshold,
	input  logic                   last_coord,
	input  logic                   last_word,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [21:0]            point_count,
	output logic                   dense_flag
);

	bapd_pkg::item_t   item;
	bapd_pkg::item_t   item_s1;
	bapd_pkg::result_t res;
	logic valid_s1;
	logic take;
	logic res_load;
	logic out_blocked;

	// Pack the input fields
	assign item.word       = bapd_pkg::word_t'(bitmap_word);
	assign item.thr        = bapd_pkg::count_t'(window_threshold);
	assign item.last_coord = last_coord;
	assign item.last_word  = last_word;

	bapd_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bapd_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.out_blocked (out_blocked),
		.take        (take),
		.res_load    (res_load),
		.res         (res)
	);

	bapd_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_load    (res_load),
		.res         (res),
		.out_blocked (out_blocked),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.point_count (point_count),
		.dense_flag  (dense_flag)
	);

endmodule

>>> hw/rtl/bapd_checker.sv
// Port-level checker for the density core, bound to the top level.
`include "bitmap_and_popcount_density_core_assert.svh"

module bapd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_coord,
	input logic        last_word,
	input logic        out_valid,
	input logic        out_stall,
	input logic [21:0] point_count,
	input logic        dense_flag
);

	// A stalled result holds until transferred
	`BAPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(point_count) && $stable(dense_flag))

	// Input backs up only behind a stalled result
	`BAPD_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall)

	// A unit-closing transfer yields a valid result on out_valid
	`BAPD_ASSERT_TWO(a_unit_result, in_valid && !in_stall && last_coord && last_word, out_valid)

endmodule

bind bitmap_and_popcount_density_core bapd_checker u_bapd_checker (.*);

>>> dv/tb_bitmap_and_popcount_density_core.sv
// Self-checking testbench for the bitmap AND popcount density core.
module tb_bitmap_and_popcount_density_core;

	localparam int unsigned ITEM_GOAL = 1600;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned GAP_MAX = 18;
	localparam int unsigned DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] bitmap_word = '0;
	logic [21:0] window_threshold = '0;
	logic last_coord = 1'b0;
	logic last_word = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [21:0] point_count;
	logic dense_flag;

	bitmap_and_popcount_density_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.bitmap_word(bitmap_word),
		.window_threshold(window_threshold),
		.last_coord(last_coord),
		.last_word(last_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.point_count(point_count),
		.dense_flag(dense_flag)
	);

	// One row of the directed table; reps > 1 streams the word back to back
	typedef struct {
		bapd_pkg::word_t  word;
		bapd_pkg::count_t thr;
		bit               lc;
		bit               lw;
		int               reps;
		bit               typed;
		bapd_pkg::count_t want_count;
		bit               want_dense;
	} row_t;

	localparam int N_ROWS = 15;
	row_t rows [N_ROWS] = '{
		'{32'hFFFF_FFFF, 22'd0,        1'b1, 1'b1, 1, 1'b1, 22'd32,       1'b1},
		'{32'h0000_0000, 22'h3F_FFFF,  1'b1, 1'b1, 1, 1'b1, 22'd0,        1'b0},
		'{32'hFFFF_0000, 22'd10,       1'b0, 1'b0, 1, 1'b0, 22'd0,        1'b0},
		'{32'h0FFF_F000, 22'd5,        1'b1, 1'b1, 1, 1'b1, 22'd12,       1'b1},
		'{32'hAAAA_AAAA, 22'd3,        1'b0, 1'b1, 1, 1'b0, 22'd0,        1'b0},
		'{32'hFFFF_FFFF, 22'd0,        1'b1, 1'b1, 1, 1'b1, 22'd16,       1'b1},
		'{32'hFFFF_FFFF, 22'd33,       1'b1, 1'b0, 1, 1'b0, 22'd0,        1'b0},
		'{32'h0000_0001, 22'd0,        1'b1, 1'b1, 1, 1'b1, 22'd33,       1'b1},
		'{32'h0000_0007, 22'd4,        1'b1, 1'b1, 1, 1'b1, 22'd3,        1'b0},
		'{32'h8000_0001, 22'd2,        1'b1, 1'b0, 1, 1'b0, 22'd0,        1'b0},
		'{32'h5555_5555, 22'd20,       1'b0, 1'b0, 1, 1'b0, 22'd0,        1'b0},
		'{32'h3333_3333, 22'd1,        1'b1, 1'b1, 1, 1'b0, 22'd0,        1'b0},
		'{32'hFFFF_FFFF, 22'h3F_FFFF,  1'b1, 1'b1, 1, 1'b1, 22'd32,       1'b0},
		'{32'h0000_0001, 22'd1,        1'b1, 1'b1, 1, 1'b1, 22'd1,        1'b1},
		'{32'h0000_0000, 22'd1,        1'b1, 1'b1, 1, 1'b1, 22'd0,        1'b0}
	};

	// Unit state of the predictor
	bapd_pkg::word_t  acc_bits = '1;
	bapd_pkg::count_t pts_sofar = '0;
	bapd_pkg::count_t peak_thr = '0;

	bapd_pkg::result_t owed_units [$];
	int unsigned words_sent = 0;
	int unsigned units_seen = 0;
	int unsigned dense_seen = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	bit in_quiet = 1'b0;
	bit out_quiet = 1'b0;

	always #2 clk = ~clk;

	// Append one expected result behind the ones already owed
	task automatic owe_unit(input bapd_pkg::result_t r);
		owed_units.insert(owed_units.size(), r);
	endtask

	// Fold one accepted word into the unit state; close the unit on last word
	task automatic merge_word(input bapd_pkg::item_t it, output bit closed,
			output bapd_pkg::result_t res);
		logic [bapd_pkg::THR_W:0] sum;
		closed = 1'b0;
		res = '0;
		acc_bits = acc_bits & it.word;
		if (it.thr > peak_thr)
			peak_thr = it.thr;
		if (it.last_coord) begin
			sum = {1'b0, pts_sofar} + (bapd_pkg::THR_W + 1)'($countones(acc_bits));
			pts_sofar = (sum > {1'b0, bapd_pkg::COUNT_MAX}) ? bapd_pkg::COUNT_MAX
				: sum[bapd_pkg::THR_W-1:0];
			acc_bits = '1;
			if (it.last_word) begin
				closed = 1'b1;
				res.point_count = pts_sofar;
				res.dense_flag = (pts_sofar >= peak_thr);
				pts_sofar = '0;
				peak_thr = '0;
			end
		end
	endtask

	// Present one word, hold it until the transfer, then update the predictor
	task automatic send_word(input bapd_pkg::item_t it, input bit hurry, output bit closed,
			output bapd_pkg::result_t res);
		int unsigned gap;
		if ($urandom_range(0, 49) == 0)
			in_quiet = !in_quiet;
		gap = (hurry || in_quiet) ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		bitmap_word <= it.word;
		window_threshold <= it.thr;
		last_coord <= it.last_coord;
		last_word <= it.last_word;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
		merge_word(it, closed, res);
	endtask

	task automatic send_checked(input bapd_pkg::item_t it);
		bit closed;
		bapd_pkg::result_t res;
		send_word(it, 1'b0, closed, res);
		if (closed)
			owe_unit(res);
	endtask

	// One well-formed unit with random content, thresholds mostly near the count
	task automatic send_random_unit();
		int unsigned ncoord;
		int unsigned ngroups;
		bapd_pkg::word_t base;
		bapd_pkg::item_t it;
		ncoord = $urandom_range(1, 4);
		ngroups = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
		for (int unsigned g = 0; g < ngroups; g++) begin
			base = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | $urandom);
			for (int unsigned c = 0; c < ncoord; c++) begin
				it.word = base | ($urandom & $urandom);
				case ($urandom_range(0, 3))
					0: it.thr = bapd_pkg::count_t'($urandom_range(0, ngroups * 20));
					1: it.thr = bapd_pkg::count_t'($urandom_range(0, 22'h3F_FFFF));
					default: it.thr = bapd_pkg::count_t'($urandom_range(0, ngroups * 32));
				endcase
				it.last_coord = (c == ncoord - 1);
				if (it.last_coord)
					it.last_word = (g == ngroups - 1);
				else
					it.last_word = ($urandom_range(0, 7) == 0);
				send_checked(it);
			end
		end
	endtask

	// Stimulus: directed table, then random units mixed with noise
	initial begin : stim
		bapd_pkg::item_t it;
		bit closed;
		bapd_pkg::result_t res;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < N_ROWS; r++) begin
			it.word = rows[r].word;
			it.thr = rows[r].thr;
			it.last_coord = rows[r].lc;
			it.last_word = rows[r].lw;
			for (int k = 0; k < rows[r].reps; k++) begin
				send_word(it, rows[r].reps > 1, closed, res);
				if (closed) begin
					if (rows[r].typed) begin
						res.point_count = rows[r].want_count;
						res.dense_flag = rows[r].want_dense;
					end
					owe_unit(res);
				end
			end
		end
		while (words_sent < ITEM_GOAL) begin
			if ($urandom_range(0, 9) == 0) begin
				it.word = $urandom;
				it.thr = bapd_pkg::count_t'($urandom_range(0, 22'h3F_FFFF));
				it.last_coord = 1'($urandom_range(0, 1));
				it.last_word = 1'($urandom_range(0, 1));
				send_checked(it);
			end else begin
				send_random_unit();
			end
		end
		in_valid <= 1'b0;
		while (owed_units.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Streamed %0d bitmap words over directed extremes and random units.",
			words_sent);
		$display("Checked %0d unit results, %0d of them dense.", units_seen, dense_seen);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Result side: random stall before each transfer, with quiet stretches
	initial begin : result_side
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				out_quiet = !out_quiet;
			hold = out_quiet ? 0 : $urandom_range(0, GAP_MAX);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
		end
	end

	// Compare each result transfer with the oldest owed unit
	always @(posedge clk) begin
		bapd_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			units_seen++;
			if (dense_flag)
				dense_seen++;
			if (owed_units.size() == 0) begin
				errors++;
				$display("%0t: unexpected result count=%0d dense=%0b", $realtime,
					point_count, dense_flag);
			end else begin
				want = owed_units.pop_front();
				if (point_count !== want.point_count) begin
					errors++;
					$display("%0t: point_count expected %0d actual %0d", $realtime,
						want.point_count, point_count);
				end
				if (dense_flag !== want.dense_flag) begin
					errors++;
					$display("%0t: dense_flag expected %0b actual %0b", $realtime,
						want.dense_flag, dense_flag);
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out with %0d results still owed.", owed_units.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule
